FILE: rtl/mei_pkg.sv
`default_nettype none

package mei_pkg;

   // Fixed field widths of the streams
   localparam int VERTEX_W     = 10;
   localparam int VERTEX_MAX   = (2 ** VERTEX_W) - 1;
   localparam int EDGE_INDEX_W = 12;
   localparam int STATUS_W     = 2;

   // Word layouts
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = STATUS_W;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NEW      = 2'd0,
      STATUS_FOUND    = 2'd1,
      STATUS_MISSING  = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD_HI,
      ST_MOD_LO,
      ST_READ,
      ST_EVAL,
      ST_SEARCH,
      ST_COMMIT,
      ST_DONE
   } state_type;

   // One restoring step of a remainder: subtract d when it fits.
   function automatic logic [VERTEX_W-1:0] rem_step(input logic [VERTEX_W-1:0] r,
                                                     input logic [47:0] d);
      logic [VERTEX_W-1:0] res;
      res = r;
      if ((d <= 48'(VERTEX_MAX)) && (48'(r) >= d)) begin
         res = r - VERTEX_W'(d);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/mesh_edge_indexer_top.sv
// mesh_edge_indexer_top
//
// Builds an edge list from a vertex adjacency stream. Each req word carries
// one (vertex, neighbor) pair; req_tlast flags the vertex's final neighbor,
// after which that vertex counts as visited. Each req word yields exactly one
// rsp word: the edge index and a status (new, found, missing, overflow).
//
// Items are handled one at a time. A new edge, or any pair that needs no
// ring lookup, goes through MOD_HI, MOD_LO, READ, EVAL, COMMIT and DONE.
// A lookup of a known edge walks the neighbor's ring through the ring and
// edge memories, one entry per cycle; each entry is read from the ring
// memory, then the edge memory, then compared, until a match or ring end.
//
// After reset a clearing pass zeroes the vertex memory (visited bits and ring
// counts) with req_tready low. Edge and ring memories are not cleared. The
// result sits in an output register: a new item is accepted while it waits,
// and a stalled receiver only holds the block at the point where the next
// result is ready to be loaded.
`default_nettype none

module mesh_edge_indexer_top #(
   parameter int MAX_VERTS   = 1024,
   parameter int MAX_EDGES   = 4096,
   parameter int MAX_VALENCE = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // [9:0] vertex, [19:10] neighbor, [23:20] zero
   input  wire logic [mei_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                             req_tlast,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [11:0] edge_index, [15:12] zero
   output logic      [mei_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic      [mei_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);

   import mei_pkg::*;

   localparam int VW  = $clog2(MAX_VERTS);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int CW  = $clog2(MAX_VALENCE + 1);
   localparam int RD  = MAX_VERTS * MAX_VALENCE;
   localparam int RW  = $clog2(RD);
   localparam int HALF = VERTEX_W / 2;

   state_type state_ff, state_in;

   logic [VERTEX_W-1:0] v_ff, v_in, n_ff, n_in;
   logic                last_ff, last_in;
   logic [VW-1:0]       clr_ff, clr_in;
   logic [ECW-1:0]      ecnt_ff, ecnt_in;
   logic [RW-1:0]       base_v_ff, base_v_in, base_n_ff, base_n_in;
   logic [CW-1:0]       cnt_v_ff, cnt_v_in, cnt_n_ff, cnt_n_in;
   logic                vis_v_ff, vis_v_in, full_ff, full_in;
   logic [CW-1:0]       k_ff, k_in;
   logic                p1_ff, p1_in, p2_ff, p2_in;
   logic [EAW-1:0]      e2_ff, e2_in;
   logic [EAW-1:0]      idx_ff, idx_in;
   status_type          status_ff, status_in;
   logic                add_ring_ff, add_ring_in, add_edge_ff, add_edge_in;
   logic                out_valid_ff, out_valid_in;
   logic [EAW-1:0]      out_idx_ff, out_idx_in;
   status_type          out_st_ff, out_st_in;

   logic [VERTEX_W-1:0] v_hi, n_hi, v_lo, n_lo;
   logic [VW-1:0]       v_idx, n_idx;

   // memory ports
   logic              vm_we;
   logic [VW-1:0]     vm_waddr;
   logic [CW:0]       vm_wdata, vm_rd_a, vm_rd_b;
   logic              ring_we;
   logic [RW-1:0]     ring_waddr, ring_raddr;
   logic [EAW-1:0]    ring_rdata;
   logic              edge_we;
   logic [2*VW-1:0]   edge_rdata;
   logic [VW-1:0]     edge_p, edge_q;

   logic accept, issue, match, search_end, rsp_load, vis_n, ring_full;

   assign v_idx  = VW'(v_ff);
   assign n_idx  = VW'(n_ff);
   assign edge_p = edge_rdata[VW-1:0];
   assign edge_q = edge_rdata[2*VW-1:VW];
   assign vis_n  = vm_rd_b[CW];
   assign ring_full = vm_rd_a[CW-1:0] >= CW'(MAX_VALENCE);

   // vertex and neighbor modulo MAX_VERTS, upper and lower halves of the steps
   always_comb begin
      v_hi = v_ff;
      n_hi = n_ff;
      v_lo = v_ff;
      n_lo = n_ff;
      for (int i = VERTEX_W - 1; i >= HALF; i--) begin
         v_hi = rem_step(v_hi, 48'(MAX_VERTS) << i);
         n_hi = rem_step(n_hi, 48'(MAX_VERTS) << i);
      end
      for (int i = HALF - 1; i >= 0; i--) begin
         v_lo = rem_step(v_lo, 48'(MAX_VERTS) << i);
         n_lo = rem_step(n_lo, 48'(MAX_VERTS) << i);
      end
   end

   // control outputs
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      accept     = req_tvalid && req_tready;
      issue      = (state_ff == ST_SEARCH) && (k_ff < cnt_n_ff);
      match      = (state_ff == ST_SEARCH) && p2_ff &&
                   (((edge_p == v_idx) && (edge_q == n_idx)) ||
                    ((edge_p == n_idx) && (edge_q == v_idx)));
      search_end = match || (!issue && !p1_ff && !p2_ff);
      rsp_load   = (state_ff == ST_DONE) && (!out_valid_ff || rsp_tready);
      vm_we      = (state_ff == ST_CLEAR) || (state_ff == ST_COMMIT);
      vm_waddr   = (state_ff == ST_CLEAR) ? clr_ff : v_idx;
      vm_wdata   = (state_ff == ST_CLEAR) ? '0 :
                   {vis_v_ff | last_ff, cnt_v_ff + CW'(add_ring_ff)};
      ring_we    = (state_ff == ST_COMMIT) && add_ring_ff;
      ring_waddr = base_v_ff + RW'(cnt_v_ff);
      ring_raddr = base_n_ff + RW'(k_ff);
      edge_we    = (state_ff == ST_COMMIT) && add_edge_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (clr_ff == VW'(MAX_VERTS - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (accept) state_in = ST_MOD_HI;
         ST_MOD_HI: state_in = ST_MOD_LO;
         ST_MOD_LO: state_in = ST_READ;
         ST_READ:   state_in = ST_EVAL;
         ST_EVAL:   state_in = vis_n ? ST_SEARCH : ST_COMMIT;
         ST_SEARCH: if (search_end) state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_DONE;
         ST_DONE:   if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // datapath
   always_comb begin
      v_in        = v_ff;
      n_in        = n_ff;
      last_in     = last_ff;
      clr_in      = clr_ff + VW'(1);
      ecnt_in     = ecnt_ff;
      base_v_in   = base_v_ff;
      base_n_in   = base_n_ff;
      cnt_v_in    = cnt_v_ff;
      cnt_n_in    = cnt_n_ff;
      vis_v_in    = vis_v_ff;
      full_in     = full_ff;
      k_in        = k_ff;
      p1_in       = 1'b0;
      p2_in       = 1'b0;
      e2_in       = ring_rdata;
      idx_in      = idx_ff;
      status_in   = status_ff;
      add_ring_in = add_ring_ff;
      add_edge_in = add_edge_ff;
      case (state_ff)
         ST_IDLE: begin
            v_in    = req_tdata[VERTEX_W-1:0];
            n_in    = req_tdata[2*VERTEX_W-1:VERTEX_W];
            last_in = req_tlast;
         end
         ST_MOD_HI: begin
            v_in = v_hi;
            n_in = n_hi;
         end
         ST_MOD_LO: begin
            v_in = v_lo;
            n_in = n_lo;
         end
         ST_READ: begin
            base_v_in = RW'(v_idx) * RW'(MAX_VALENCE);
            base_n_in = RW'(n_idx) * RW'(MAX_VALENCE);
         end
         ST_EVAL: begin
            cnt_v_in    = vm_rd_a[CW-1:0];
            vis_v_in    = vm_rd_a[CW];
            cnt_n_in    = vm_rd_b[CW-1:0];
            full_in     = ring_full;
            k_in        = '0;
            idx_in      = '0;
            add_ring_in = 1'b0;
            add_edge_in = 1'b0;
            if (!vis_n) begin
               if (ring_full || (ecnt_ff >= ECW'(MAX_EDGES))) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  status_in   = STATUS_NEW;
                  idx_in      = ecnt_ff[EAW-1:0];
                  add_ring_in = 1'b1;
                  add_edge_in = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            // ring read -> edge read -> compare, one entry entering per cycle
            p1_in = issue;
            p2_in = p1_ff;
            if (issue) begin
               k_in = k_ff + CW'(1);
            end
            if (match) begin
               if (full_ff) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  status_in   = STATUS_FOUND;
                  idx_in      = e2_ff;
                  add_ring_in = 1'b1;
               end
            end else if (search_end) begin
               status_in = STATUS_MISSING;
            end
         end
         ST_COMMIT: begin
            if (add_edge_ff) begin
               ecnt_in = ecnt_ff + ECW'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      out_st_in    = out_st_ff;
      if (rsp_load) begin
         out_valid_in = 1'b1;
         out_idx_in   = idx_ff;
         out_st_in    = status_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         ecnt_ff      <= '0;
         p1_ff        <= 1'b0;
         p2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ecnt_ff      <= ecnt_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      n_ff        <= n_in;
      last_ff     <= last_in;
      base_v_ff   <= base_v_in;
      base_n_ff   <= base_n_in;
      cnt_v_ff    <= cnt_v_in;
      cnt_n_ff    <= cnt_n_in;
      vis_v_ff    <= vis_v_in;
      full_ff     <= full_in;
      k_ff        <= k_in;
      e2_ff       <= e2_in;
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      add_ring_ff <= add_ring_in;
      add_edge_ff <= add_edge_in;
      out_idx_ff  <= out_idx_in;
      out_st_ff   <= out_st_in;
   end

   mei_vertex_mem #(
      .DEPTH (MAX_VERTS),
      .WIDTH (CW + 1)
   ) u_vertex_mem (
      .clock     (clock),
      .wr_en     (vm_we),
      .wr_addr   (vm_waddr),
      .wr_data   (vm_wdata),
      .rd_addr_a (v_idx),
      .rd_addr_b (n_idx),
      .rd_data_a (vm_rd_a),
      .rd_data_b (vm_rd_b)
   );

   mei_ram #(
      .DEPTH (RD),
      .WIDTH (EAW)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (idx_ff),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   mei_ram #(
      .DEPTH (MAX_EDGES),
      .WIDTH (2 * VW)
   ) u_edge_mem (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (ecnt_ff[EAW-1:0]),
      .wr_data ({n_idx, v_idx}),
      .rd_addr (ring_rdata),
      .rd_data (edge_rdata)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(EDGE_INDEX_W'(out_idx_ff));
   assign rsp_tuser  = out_st_ff;

endmodule

`default_nettype wire

FILE: rtl/mei_ram.sv
`default_nettype none

module mei_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 12,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/mei_vertex_mem.sv
`default_nettype none

// Per-vertex entry: {visited, ring fill count}. Two read ports, one write port.
module mei_vertex_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 6,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_a,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

FILE: rtl/mei_checker.sv
`default_nettype none

module mei_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [mei_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic [mei_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);

   import mei_pkg::*;

   // clearing pass holds off input right after reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("req_tready high right after reset");

   // one word in flight: no second accept in the following cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after an accepted word");

   // failed lookups and overflows carry edge index zero
   a_error_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tuser == STATUS_MISSING) || (rsp_tuser == STATUS_OVERFLOW)))
      |-> (rsp_tdata == '0))
      else $error("nonzero edge index with error status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

endmodule

bind mesh_edge_indexer_top mei_checker u_mei_checker (.*);

`default_nettype wire

FILE: tb/sv/mesh_edge_indexer_top_tb.sv
`timescale 1ns / 1ps

module mesh_edge_indexer_top_tb;
   import mei_pkg::*;

   localparam int VERTS          = 1024;
   localparam int STORE_DEPTH    = 4096;
   localparam int RING_DEPTH     = 16;
   localparam int RANDOM_PAIRS   = 550;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 40;

   typedef struct packed {
      logic [9:0] vertex;
      logic [9:0] neighbor;
      logic       last;
   } adjacency_pair_type;

   typedef struct packed {
      logic [11:0] edge_index;
      status_type  status;
   } edge_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   // shadow of the block's state, updated as words are accepted
   bit          visited_vertex [VERTS];
   logic [9:0]  edge_src [STORE_DEPTH];
   logic [9:0]  edge_dst [STORE_DEPTH];
   logic [11:0] edge_ring [VERTS][RING_DEPTH];
   int          ring_fill [VERTS];
   int          edge_total = 0;

   adjacency_pair_type pending_pairs[$];
   edge_result_type    expected_results[$];
   adjacency_pair_type pair_on_bus;

   int pairs_queued  = 0;
   int pairs_sent    = 0;
   int words_checked = 0;
   int failures      = 0;
   int status_tally [4];
   int send_gap      = 0;
   int recv_stall    = 0;
   bit send_calm     = 1'b0;
   bit recv_calm     = 1'b0;
   int idle_cycles   = 0;

   mesh_edge_indexer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic int wait_draw(input bit calm);
      return calm ? 0 : int'($urandom_range(0, 16));
   endfunction

   // Allocates or looks up the edge for one pair and updates the shadow state.
   function automatic edge_result_type index_edge(input adjacency_pair_type p);
      edge_result_type r;
      bit              ring_full;
      bit              hit;
      logic [11:0]     hit_edge;
      logic [11:0]     e;
      r.edge_index = '0;
      hit = 1'b0;
      hit_edge = '0;
      ring_full = ring_fill[p.vertex] >= RING_DEPTH;
      if (!visited_vertex[p.neighbor]) begin
         if (ring_full || edge_total >= STORE_DEPTH) begin
            r.status = STATUS_OVERFLOW;
         end else begin
            r.edge_index = edge_total[11:0];
            edge_src[edge_total] = p.vertex;
            edge_dst[edge_total] = p.neighbor;
            edge_ring[p.vertex][ring_fill[p.vertex]] = edge_total[11:0];
            ring_fill[p.vertex]++;
            edge_total++;
            r.status = STATUS_NEW;
         end
      end else begin
         for (int k = 0; k < ring_fill[p.neighbor] && !hit; k++) begin
            e = edge_ring[p.neighbor][k];
            if ((edge_src[e] == p.vertex && edge_dst[e] == p.neighbor) ||
                (edge_src[e] == p.neighbor && edge_dst[e] == p.vertex)) begin
               hit = 1'b1;
               hit_edge = e;
            end
         end
         if (!hit) begin
            r.status = STATUS_MISSING;
         end else if (ring_full) begin
            r.status = STATUS_OVERFLOW;
         end else begin
            r.edge_index = hit_edge;
            edge_ring[p.vertex][ring_fill[p.vertex]] = hit_edge;
            ring_fill[p.vertex]++;
            r.status = STATUS_FOUND;
         end
      end
      if (p.last) begin
         visited_vertex[p.vertex] = 1'b1;
      end
      return r;
   endfunction

   task automatic queue_pair(input int vertex, input int neighbor, input bit last);
      adjacency_pair_type p;
      p.vertex = vertex[9:0];
      p.neighbor = neighbor[9:0];
      p.last = last;
      pending_pairs = {pending_pairs, p};
      pairs_queued++;
   endtask

   task automatic wait_for_idle();
      while (pending_pairs.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results = {expected_results, index_edge(pair_on_bus)};
            pairs_sent++;
         end
         if (req_tvalid && !req_tready) begin
            // hold the word until taken
         end else if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_pairs.size() != 0) begin
            pair_on_bus = pending_pairs.pop_front();
            req_tdata <= REQ_TDATA_W'({pair_on_bus.neighbor, pair_on_bus.vertex});
            req_tlast <= pair_on_bus.last;
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            send_gap <= wait_draw(send_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin : rsp_monitor
      edge_result_type want;
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_stall <= 0;
      end else begin
         stall = recv_stall;
         if (rsp_tvalid && rsp_tready) begin
            words_checked++;
            status_tally[rsp_tuser]++;
            if (expected_results.size() == 0) begin
               $error("unexpected rsp word: edge_index %0d status %0d",
                      rsp_tdata[11:0], rsp_tuser);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[11:0] != want.edge_index) begin
                  $error("edge_index: expected %0d, actual %0d",
                         want.edge_index, rsp_tdata[11:0]);
                  failures++;
               end
               if (rsp_tuser != want.status) begin
                  $error("status: expected %s, actual %0d", want.status.name(), rsp_tuser);
                  failures++;
               end
            end
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            stall = wait_draw(recv_calm);
         end
         // the stall only runs down while a word is waiting
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            recv_stall <= rsp_tvalid ? stall - 1 : stall;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall <= 0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      bit mesh_adj [20][20];
      int nbrs[$];
      int mesh_size;
      int base;
      int density;
      int tmp;
      int b;
      bit drop_last;

      // directed: extremes, self loops, lookups, ring and search corner cases
      queue_pair(0, 1023, 0);
      queue_pair(0, 0, 0);
      queue_pair(0, 3, 0);
      queue_pair(0, 1, 1);
      queue_pair(1, 0, 0);
      queue_pair(1023, 0, 1);
      queue_pair(2, 1023, 0);
      queue_pair(0, 0, 0);
      for (int k = 0; k < RING_DEPTH; k++) queue_pair(3, 200 + k, 0);
      queue_pair(3, 216, 0);     // ring full on a new edge
      queue_pair(3, 0, 0);       // ring full on a found edge
      queue_pair(3, 1023, 1);    // search miss wins over a full ring

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait_for_idle();

      // random meshes: ascending vertex blocks with symmetric adjacency, plus noise
      while (pairs_queued < RANDOM_PAIRS) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               queue_pair($urandom_range(0, VERTS - 1), $urandom_range(0, VERTS - 1),
                          $urandom_range(0, 1));
            end
         end else begin
            mesh_size = $urandom_range(3, 20);
            base = $urandom_range(0, VERTS - mesh_size);
            density = ($urandom_range(0, 5) == 0) ? 85 : 25;
            for (int i = 0; i < mesh_size; i++) begin
               for (int j = i + 1; j < mesh_size; j++) begin
                  mesh_adj[i][j] = (j == i + 1) || ($urandom_range(0, 99) < density);
                  mesh_adj[j][i] = mesh_adj[i][j];
               end
            end
            for (int i = 0; i < mesh_size && pairs_queued < RANDOM_PAIRS; i++) begin
               nbrs.delete();
               for (int j = 0; j < mesh_size; j++) begin
                  if (j != i && mesh_adj[i][j]) nbrs = {nbrs, base + j};
               end
               if ($urandom_range(0, 9) == 0) nbrs = {nbrs, base + i};
               for (int a = nbrs.size() - 1; a > 0; a--) begin
                  b = $urandom_range(0, a);
                  tmp = nbrs[a];
                  nbrs[a] = nbrs[b];
                  nbrs[b] = tmp;
               end
               drop_last = ($urandom_range(0, 11) == 0);
               foreach (nbrs[k]) begin
                  if ($urandom_range(0, 19) == 0) begin
                     queue_pair($urandom_range(0, VERTS - 1), $urandom_range(0, VERTS - 1),
                                $urandom_range(0, 1));
                  end
                  queue_pair(base + i, nbrs[k], (k == nbrs.size() - 1) && !drop_last);
               end
            end
         end
      end
      wait_for_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d adjacency words, checked %0d results: %0d new, %0d found,",
               pairs_sent, words_checked, status_tally[0], status_tally[1]);
      $display("%0d missing, %0d overflow; edge store reached %0d entries",
               status_tally[2], status_tally[3], edge_total);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
